// ===== src/dei_pkg.sv =====
package dei_pkg;

    localparam logic [1:0] ACTION_SAMPLE = 2'd0;
    localparam logic [1:0] ACTION_CLOCK  = 2'd1;
    localparam logic [1:0] ACTION_START  = 2'd2;

    localparam logic [1:0] METHOD_TRAPEZOID = 2'd0;
    localparam logic [1:0] METHOD_PREVIOUS  = 2'd1;
    localparam logic [1:0] METHOD_NEW       = 2'd2;

    localparam logic REG_METHOD = 1'b0;
    localparam logic REG_MARGIN = 1'b1;

    localparam logic KIND_ENERGY = 1'b0;
    localparam logic KIND_CLOCK  = 1'b1;

    localparam logic [1:0]  METHOD_RESET = 2'd2;
    localparam logic [16:0] MARGIN_RESET = 17'd5400;
    localparam logic [16:0] DELAY_MAX    = 17'd86401;

    // ceil(2^70 / 28125): exact quotient for any 55-bit dividend
    localparam logic [55:0] RECIP    = 56'd41976590958841291;
    localparam logic [27:0] RECIP_LO = RECIP[27:0];
    localparam logic [27:0] RECIP_HI = RECIP[55:28];

    // 7200000 * 2^40: magnitudes at or above this saturate the mwh output
    localparam logic [63:0] SAT_MAG = 64'd7916483719987200000;

    localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};

    localparam logic signed [40:0] MWH_MAX = {1'b0, {40{1'b1}}};
    localparam logic signed [40:0] MWH_MIN = {1'b1, {40{1'b0}}};

    typedef struct packed {
        logic        kind;
        logic        cleared;
        logic [16:0] delay;
    } meta_t;

endpackage

// ===== src/daily_energy_integrator.sv =====
// a result passes stages 1 to 3 and then the conversion stages a, b and c before it is valid
// one transaction per cycle while item_ready is high; the accumulator add with saturation
// is combinational into the total register, the mwh divide is a 3-stage constant multiply
// transactions that give no result (nan sample, invalid clock, start) finish on acceptance
// reset (rst_n low, asynchronous): total, stored day, baseline and last power cleared,
// method back to new sample, margin back to 5400 s
module daily_energy_integrator (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           action,
    input  logic [31:0]          now_ms,
    input  logic signed [31:0]   power_mw,
    input  logic                 power_valid,
    input  logic                 time_valid,
    input  logic [8:0]           year_day,
    input  logic [4:0]           hour_now,
    input  logic [5:0]           minute_now,
    input  logic [5:0]           second_now,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic                 result_kind,
    output logic signed [40:0]   energy_mwh,
    output logic                 was_cleared,
    output logic [16:0]          next_check_seconds,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [16:0]          cfg_data
);
    import dei_pkg::*;

    logic [1:0]          method_reg;
    logic [16:0]         margin_reg;

    logic signed [63:0]  acc_reg;
    logic signed [63:0]  acc_next;
    logic signed [31:0]  prev_power_reg;
    logic [31:0]         prev_time_reg;
    logic [8:0]          stored_day_reg;

    logic                item_accept;
    logic                take_sample;
    logic                take_clock;
    logic                take_start;
    logic                enters;
    logic                day_clear;

    logic signed [33:0]  step_sum;
    logic signed [33:0]  step_negated;
    logic                step_neg;
    logic [32:0]         step_mag;
    logic [31:0]         dt;

    logic                s1_valid_reg;
    logic                s1_kind_reg;
    logic                s1_cleared_reg;
    logic                s1_neg_reg;
    logic [32:0]         s1_mag_reg;
    logic [31:0]         s1_dt_reg;
    logic [4:0]          s1_hour_reg;
    logic [5:0]          s1_minute_reg;
    logic [5:0]          s1_second_reg;

    logic                s2_valid_reg;
    meta_t               s2_meta_reg;
    logic                s2_neg_reg;
    logic [63:0]         s2_prod_reg;

    logic                s3_valid_reg;
    meta_t               s3_meta_reg;
    logic signed [63:0]  s3_acc_reg;

    logic                free1;
    logic                free2;
    logic                free3;
    logic                move23;
    logic                conv_ready;

    logic [4:0]          hour_sat;
    logic [5:0]          minute_sat;
    logic [5:0]          second_sat;
    logic [10:0]         minutes_left;
    logic [16:0]         until_midnight;
    logic [16:0]         delay;
    meta_t               s1_meta;
    logic [64:0]         prod_full;

    logic signed [65:0]  acc_ext;
    logic signed [65:0]  prod_ext;
    logic signed [65:0]  acc_sum;
    logic signed [63:0]  acc_sat;

    meta_t               conv_meta;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= METHOD_RESET;
            margin_reg <= MARGIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_METHOD: method_reg <= cfg_data[1:0];
                REG_MARGIN: margin_reg <= cfg_data;
                default:    method_reg <= method_reg;
            endcase
        end
    end

    assign free3  = !s3_valid_reg || conv_ready;
    assign free2  = !s2_valid_reg || free3;
    assign free1  = !s1_valid_reg || free2;
    assign move23 = s2_valid_reg && free3;

    assign item_ready  = free1;
    assign item_accept = item_valid && item_ready;
    assign take_sample = (action == ACTION_SAMPLE) && power_valid;
    assign take_clock  = (action == ACTION_CLOCK) && time_valid;
    assign take_start  = (action == ACTION_START);
    assign enters      = take_sample || take_clock;
    assign day_clear   = (stored_day_reg != year_day) && (stored_day_reg != 9'd0);

    // step weight, doubled so that the trapezoid needs no halving
    always_comb
    begin
        case (method_reg)
            METHOD_TRAPEZOID: step_sum = 34'(prev_power_reg) + 34'(power_mw);
            METHOD_PREVIOUS:  step_sum = 34'(prev_power_reg) <<< 1;
            METHOD_NEW:       step_sum = 34'(power_mw) <<< 1;
            default:          step_sum = '0;
        endcase
    end

    assign step_neg     = step_sum[33];
    assign step_negated = -step_sum;
    assign step_mag     = step_neg ? step_negated[32:0] : step_sum[32:0];
    assign dt           = now_ms - prev_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_power_reg <= '0;
            prev_time_reg  <= '0;
            stored_day_reg <= '0;
        end
        else if (item_accept)
        begin
            if (take_sample)
            begin
                prev_power_reg <= power_mw;
                prev_time_reg  <= now_ms;
            end
            if (take_start)
            begin
                prev_time_reg <= now_ms;
            end
            if (take_clock)
            begin
                stored_day_reg <= year_day;
            end
        end
    end

    // stage 1: transaction register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (free1)
            begin
                s1_valid_reg <= item_accept && enters;
            end
            if (free2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (free3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && enters)
        begin
            s1_kind_reg    <= take_clock ? KIND_CLOCK : KIND_ENERGY;
            s1_cleared_reg <= take_clock && day_clear;
            s1_neg_reg     <= step_neg;
            s1_mag_reg     <= step_mag;
            s1_dt_reg      <= dt;
            s1_hour_reg    <= hour_now;
            s1_minute_reg  <= minute_now;
            s1_second_reg  <= second_now;
        end
    end

    // stage 2: energy step product and clock delay
    assign hour_sat   = (s1_hour_reg > 5'd23) ? 5'd23 : s1_hour_reg;
    assign minute_sat = (s1_minute_reg > 6'd59) ? 6'd59 : s1_minute_reg;
    assign second_sat = (s1_second_reg > 6'd60) ? 6'd60 : s1_second_reg;

    assign minutes_left   = 11'(5'd23 - hour_sat) * 11'd60 + 11'(6'd59 - minute_sat);
    assign until_midnight = 17'(minutes_left) * 17'd60 + 17'(6'd60 - second_sat);
    assign delay = (until_midnight > margin_reg) ? (until_midnight - margin_reg)
                                                 : (until_midnight + 17'd1);

    always_comb
    begin
        s1_meta.kind    = s1_kind_reg;
        s1_meta.cleared = s1_cleared_reg;
        s1_meta.delay   = (s1_kind_reg == KIND_CLOCK) ? delay : 17'd0;
    end

    assign prod_full = {33'b0, s1_dt_reg} * {32'b0, s1_mag_reg};

    always_ff @(posedge clk)
    begin
        if (free2 && s1_valid_reg)
        begin
            s2_meta_reg <= s1_meta;
            s2_neg_reg  <= s1_neg_reg;
            s2_prod_reg <= prod_full[63:0];
        end
    end

    // stage 3: saturating accumulate, the total is snapshotted with the transaction
    assign acc_ext  = {{2{acc_reg[63]}}, acc_reg};
    assign prod_ext = {2'b00, s2_prod_reg};
    assign acc_sum  = s2_neg_reg ? (acc_ext - prod_ext) : (acc_ext + prod_ext);

    always_comb
    begin
        if ((acc_sum[65:63] == 3'b000) || (acc_sum[65:63] == 3'b111))
        begin
            acc_sat = acc_sum[63:0];
        end
        else
        begin
            acc_sat = acc_sum[65] ? ACC_MIN : ACC_MAX;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (move23)
        begin
            if (s2_meta_reg.cleared)
            begin
                acc_next = '0;
            end
            else if (s2_meta_reg.kind == KIND_ENERGY)
            begin
                acc_next = acc_sat;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move23)
        begin
            s3_meta_reg <= s2_meta_reg;
            s3_acc_reg  <= acc_next;
        end
    end

    // stages 4 to 6: conversion to mwh
    dei_mwh_conv u_mwh_conv (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s3_valid_reg),
        .in_ready   (conv_ready),
        .acc        (s3_acc_reg),
        .in_meta    (s3_meta_reg),
        .out_valid  (result_valid),
        .out_ready  (result_ready),
        .out_energy (energy_mwh),
        .out_meta   (conv_meta)
    );

    assign result_kind        = conv_meta.kind;
    assign was_cleared        = conv_meta.cleared;
    assign next_check_seconds = conv_meta.delay;

`ifndef SYNTHESIS
    a_energy_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == KIND_ENERGY) |-> !was_cleared
            && (next_check_seconds == 17'd0))
        else $error("energy update carries clock fields");

    a_delay_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_kind == KIND_CLOCK) |-> (next_check_seconds != 17'd0)
            && (next_check_seconds <= DELAY_MAX))
        else $error("clock delay out of range");

    a_day_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(item_accept && take_clock) |=> $stable(stored_day_reg))
        else $error("stored day changed without a clock transaction");

    a_time_base: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && (take_sample || take_start) |=> prev_time_reg == $past(now_ms))
        else $error("time baseline not taken");

    a_clear_total: assert property (@(posedge clk) disable iff (!rst_n)
        move23 && s2_meta_reg.cleared |=> acc_reg == 64'sd0)
        else $error("new day did not clear the total");
`endif

endmodule

// ===== src/dei_mwh_conv.sv =====
module dei_mwh_conv (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [63:0]    acc,
    input  dei_pkg::meta_t        in_meta,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [40:0]    out_energy,
    output dei_pkg::meta_t        out_meta
);
    import dei_pkg::*;

    logic                a_valid_reg;
    meta_t               a_meta_reg;
    logic                a_neg_reg;
    logic                a_sat_reg;
    logic [54:0]         a_x_reg;

    logic                b_valid_reg;
    meta_t               b_meta_reg;
    logic                b_neg_reg;
    logic                b_sat_reg;
    logic [55:0]         b_pp_ll_reg;
    logic [55:0]         b_pp_lh_reg;
    logic [55:0]         b_pp_hl_reg;
    logic [55:0]         b_pp_hh_reg;

    logic                c_valid_reg;
    meta_t               c_meta_reg;
    logic signed [40:0]  c_energy_reg;

    logic                free_a;
    logic                free_b;
    logic                free_c;

    logic [63:0]         acc_neg;
    logic [63:0]         acc_mag;
    logic [110:0]        prod_sum;
    logic [40:0]         quot;
    logic signed [40:0]  energy_next;

    assign free_c   = !c_valid_reg || out_ready;
    assign free_b   = !b_valid_reg || free_c;
    assign free_a   = !a_valid_reg || free_b;
    assign in_ready = free_a;

    // magnitude of the total, rounded toward zero after the divide
    assign acc_neg = 64'(-acc);
    assign acc_mag = acc[63] ? acc_neg : acc;

    assign prod_sum = (111'(b_pp_hh_reg) << 56)
                    + (111'(b_pp_hl_reg) << 28)
                    + (111'(b_pp_lh_reg) << 28)
                    + 111'(b_pp_ll_reg);
    assign quot = {1'b0, prod_sum[109:70]};

    always_comb
    begin
        if (b_sat_reg)
        begin
            energy_next = b_neg_reg ? MWH_MIN : MWH_MAX;
        end
        else if (b_neg_reg)
        begin
            energy_next = -$signed(quot);
        end
        else
        begin
            energy_next = $signed(quot);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (free_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (free_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (free_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free_a && in_valid)
        begin
            a_meta_reg <= in_meta;
            a_neg_reg  <= acc[63];
            a_sat_reg  <= (acc_mag >= SAT_MAG);
            a_x_reg    <= acc_mag[62:8];
        end
        if (free_b && a_valid_reg)
        begin
            b_meta_reg  <= a_meta_reg;
            b_neg_reg   <= a_neg_reg;
            b_sat_reg   <= a_sat_reg;
            b_pp_ll_reg <= 56'(a_x_reg[27:0]) * 56'(RECIP_LO);
            b_pp_lh_reg <= 56'(a_x_reg[27:0]) * 56'(RECIP_HI);
            b_pp_hl_reg <= 56'(a_x_reg[54:28]) * 56'(RECIP_LO);
            b_pp_hh_reg <= 56'(a_x_reg[54:28]) * 56'(RECIP_HI);
        end
        if (free_c && b_valid_reg)
        begin
            c_meta_reg   <= b_meta_reg;
            c_energy_reg <= energy_next;
        end
    end

    assign out_valid  = c_valid_reg;
    assign out_energy = c_energy_reg;
    assign out_meta   = c_meta_reg;

endmodule
